// ----- sv/bse_pkg.sv -----
// Shared types, constants and saturation helpers for the burning ship escape-time engine.
package bse_pkg;

  localparam int FRAC_BITS = 44;
  localparam int DIM_BITS  = 12;
  localparam int VAL_W     = FRAC_BITS + 4;
  localparam int STEP_W    = VAL_W - 1;
  localparam int HALF_W    = VAL_W / 2;
  localparam int HI_W      = VAL_W - HALF_W;
  localparam int PROD_W    = 2 * VAL_W;
  localparam int CP_W      = DIM_BITS + STEP_W;
  localparam int CLO_W     = DIM_BITS + HALF_W;
  localparam int CHI_W     = DIM_BITS + STEP_W - HALF_W;
  localparam int WIDE_W    = CP_W + 2;
  localparam int CNT_W     = 12;
  localparam int CFG_IDX_W = 3;

  typedef logic signed [VAL_W-1:0]  val_t;
  typedef logic        [VAL_W-1:0]  mag_t;
  typedef logic        [VAL_W-2:0]  sq_t;
  typedef logic        [PROD_W-1:0] prod_t;
  typedef logic signed [WIDE_W-1:0] wide_t;
  typedef logic        [STEP_W-1:0] step_t;
  typedef logic        [DIM_BITS-1:0] dim_t;
  typedef logic        [CNT_W-1:0]  cnt_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_REAL_ORIGIN = 3'd0,
    REG_IMAG_ORIGIN = 3'd1,
    REG_REAL_STEP   = 3'd2,
    REG_IMAG_STEP   = 3'd3,
    REG_ITER_LIMIT  = 3'd4
  } cfg_reg_e;

  localparam val_t  REAL_ORIGIN_RST = -48'sd28763224182620;
  localparam val_t  IMAG_ORIGIN_RST = -48'sd63331869760;
  localparam step_t REAL_STEP_RST   = 47'd223338299;
  localparam step_t IMAG_STEP_RST   = 47'd61847529;
  localparam cnt_t  ITER_LIMIT_RST  = 12'd696;

  localparam val_t VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam val_t VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
  localparam mag_t FOUR    = mag_t'(1) << (FRAC_BITS + 2);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;
    logic coord_mul;
    logic coord_sum;
    logic mul;
    logic sum;
    logic upd;
    logic out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic lim_zero;
    logic escape;
    logic last;
    logic out_free;
  } sts_t;

  // Clamps a wide signed sum to the signed value range.
  function automatic val_t sat_wide(wide_t v);
    logic [WIDE_W-VAL_W:0] top;
    top = v[WIDE_W-1:VAL_W-1];
    if ((&top) || !(|top)) begin
      return val_t'(v[VAL_W-1:0]);
    end else if (v[WIDE_W-1]) begin
      return VAL_MIN;
    end else begin
      return VAL_MAX;
    end
  endfunction

  // Truncates a nonnegative product by a fixed shift and saturates it.
  function automatic sq_t sat_prod(prod_t p, int unsigned sh);
    prod_t r;
    r = p >> sh;
    if (|r[PROD_W-1:VAL_W-1]) begin
      return '1;
    end else begin
      return r[VAL_W-2:0];
    end
  endfunction

endpackage

// ----- sv/bse_ctrl.sv -----
// Controller state machine that sequences coordinate setup, map iterations and result handoff.
module bse_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  bse_pkg::sts_t sts_i,
  output bse_pkg::cmd_t cmd_o
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_CMUL = 7'b0000010,
    S_CSUM = 7'b0000100,
    S_MUL  = 7'b0001000,
    S_SUM  = 7'b0010000,
    S_UPD  = 7'b0100000,
    S_FIN  = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        cmd_o.load_in = in_valid_i;
        if (in_valid_i) begin
          state_d = S_CMUL;
        end
      end
      S_CMUL: begin
        cmd_o.coord_mul = 1'b1;
        state_d = S_CSUM;
      end
      S_CSUM: begin
        cmd_o.coord_sum = 1'b1;
        state_d = sts_i.lim_zero ? S_FIN : S_MUL;
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d = S_SUM;
      end
      S_SUM: begin
        cmd_o.sum = 1'b1;
        state_d = S_UPD;
      end
      S_UPD: begin
        cmd_o.upd = !sts_i.escape;
        if (sts_i.escape || sts_i.last) begin
          state_d = S_FIN;
        end else begin
          state_d = S_MUL;
        end
      end
      S_FIN: begin
        cmd_o.out_load = sts_i.out_free;
        if (sts_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign in_stall_o = (state_q != S_IDLE);

endmodule

// ----- sv/bse_datapath.sv -----
// Datapath with coordinate mapping, split multipliers, saturation, iteration counter and output register.
module bse_datapath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  bse_pkg::cmd_t        cmd_i,
  output bse_pkg::sts_t        sts_o,
  input  bse_pkg::dim_t        pixel_col_i,
  input  bse_pkg::dim_t        pixel_row_i,
  input  bse_pkg::val_t        real_origin_i,
  input  bse_pkg::val_t        imag_origin_i,
  input  bse_pkg::step_t       real_step_i,
  input  bse_pkg::step_t       imag_step_i,
  input  bse_pkg::cnt_t        iteration_limit_i,
  input  logic                 out_stall_i,
  output logic                 out_valid_o,
  output bse_pkg::dim_t        out_col_o,
  output bse_pkg::dim_t        out_row_o,
  output bse_pkg::cnt_t        iterations_o,
  output logic                 inside_res_o
);

  localparam int HALF_W = bse_pkg::HALF_W;
  localparam int HI_W   = bse_pkg::HI_W;
  localparam int VAL_W  = bse_pkg::VAL_W;
  localparam int STEP_W = bse_pkg::STEP_W;
  localparam int CP_W   = bse_pkg::CP_W;
  localparam int WIDE_W = bse_pkg::WIDE_W;
  localparam int CNT_W  = bse_pkg::CNT_W;

  bse_pkg::dim_t col_q, row_q;
  logic [bse_pkg::CLO_W-1:0] re_lo_q, im_lo_q;
  logic [bse_pkg::CHI_W-1:0] re_hi_q, im_hi_q;
  bse_pkg::val_t cr_q, ci_q, zr_q, zi_q;
  bse_pkg::cnt_t n_q;

  logic [2*HALF_W-1:0]    aa00_q, bb00_q, ab00_q;
  logic [HALF_W+HI_W-1:0] aa01_q, bb01_q, ab01_q, ab10_q;
  logic [2*HI_W-1:0]      aa11_q, bb11_q, ab11_q;
  bse_pkg::sq_t aa_q, bb_q, ab2_q;

  logic out_valid_q;
  bse_pkg::dim_t out_col_q, out_row_q;
  bse_pkg::cnt_t out_iter_q;
  logic out_inside_q;

  bse_pkg::mag_t a, b;
  logic [HALF_W-1:0] a0, b0;
  logic [HI_W-1:0]   a1, b1;
  logic [CP_W-1:0] p_re, p_im;
  bse_pkg::wide_t s_re, s_im;
  bse_pkg::prod_t aa_p, bb_p, ab_p;
  bse_pkg::mag_t sq_sum;
  bse_pkg::wide_t zr_w, zi_w;
  logic [CNT_W:0] n_inc;

  assign a  = bse_pkg::mag_t'(zr_q[VAL_W-1] ? -zr_q : zr_q);
  assign b  = bse_pkg::mag_t'(zi_q[VAL_W-1] ? -zi_q : zi_q);
  assign a0 = a[HALF_W-1:0];
  assign a1 = a[VAL_W-1:HALF_W];
  assign b0 = b[HALF_W-1:0];
  assign b1 = b[VAL_W-1:HALF_W];

  assign p_re = (CP_W'(re_hi_q) << HALF_W) + CP_W'(re_lo_q);
  assign p_im = (CP_W'(im_hi_q) << HALF_W) + CP_W'(im_lo_q);
  assign s_re = WIDE_W'(real_origin_i) + $signed(WIDE_W'(p_re));
  assign s_im = WIDE_W'(imag_origin_i) + $signed(WIDE_W'(p_im));

  assign aa_p = {aa11_q, aa00_q} + (bse_pkg::PROD_W'(aa01_q) << (HALF_W + 1));
  assign bb_p = {bb11_q, bb00_q} + (bse_pkg::PROD_W'(bb01_q) << (HALF_W + 1));
  assign ab_p = {ab11_q, ab00_q}
              + (bse_pkg::PROD_W'({1'b0, ab01_q} + {1'b0, ab10_q}) << HALF_W);

  assign sq_sum = {1'b0, aa_q} + {1'b0, bb_q};
  assign zr_w   = $signed(WIDE_W'(aa_q)) - $signed(WIDE_W'(bb_q)) + WIDE_W'(cr_q);
  assign zi_w   = $signed(WIDE_W'(ab2_q)) + WIDE_W'(ci_q);
  assign n_inc  = {1'b0, n_q} + 1'b1;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      col_q <= pixel_col_i;
      row_q <= pixel_row_i;
    end
    if (cmd_i.coord_mul) begin
      re_lo_q <= col_q * real_step_i[HALF_W-1:0];
      re_hi_q <= col_q * real_step_i[STEP_W-1:HALF_W];
      im_lo_q <= row_q * imag_step_i[HALF_W-1:0];
      im_hi_q <= row_q * imag_step_i[STEP_W-1:HALF_W];
    end
    if (cmd_i.coord_sum) begin
      cr_q <= bse_pkg::sat_wide(s_re);
      ci_q <= bse_pkg::sat_wide(s_im);
      zr_q <= bse_pkg::sat_wide(s_re);
      zi_q <= bse_pkg::sat_wide(s_im);
      n_q  <= '0;
    end
    if (cmd_i.mul) begin
      aa00_q <= a0 * a0;
      aa01_q <= a0 * a1;
      aa11_q <= a1 * a1;
      bb00_q <= b0 * b0;
      bb01_q <= b0 * b1;
      bb11_q <= b1 * b1;
      ab00_q <= a0 * b0;
      ab01_q <= a0 * b1;
      ab10_q <= a1 * b0;
      ab11_q <= a1 * b1;
    end
    if (cmd_i.sum) begin
      aa_q  <= bse_pkg::sat_prod(aa_p, bse_pkg::FRAC_BITS);
      bb_q  <= bse_pkg::sat_prod(bb_p, bse_pkg::FRAC_BITS);
      ab2_q <= bse_pkg::sat_prod(ab_p, bse_pkg::FRAC_BITS - 1);
    end
    if (cmd_i.upd) begin
      zr_q <= bse_pkg::sat_wide(zr_w);
      zi_q <= bse_pkg::sat_wide(zi_w);
      n_q  <= n_inc[CNT_W-1:0];
    end
    if (cmd_i.out_load) begin
      out_col_q    <= col_q;
      out_row_q    <= row_q;
      out_iter_q   <= n_q;
      out_inside_q <= (n_q == iteration_limit_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign sts_o.lim_zero = (iteration_limit_i == '0);
  assign sts_o.escape   = (sq_sum >= bse_pkg::FOUR);
  assign sts_o.last     = (n_inc == {1'b0, iteration_limit_i});
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  assign out_valid_o  = out_valid_q;
  assign out_col_o    = out_col_q;
  assign out_row_o    = out_row_q;
  assign iterations_o = out_iter_q;
  assign inside_res_o = out_inside_q;

endmodule

// ----- sv/burning_ship_escape_time.sv -----
// A request runs coordinate setup, R map rounds, then handoff; R is the map rounds run:
// the iterations done, plus one more when the point escapes before the limit.
// A new request is taken only once the last result is loaded; each round passes through
// the split 24x24 multiplier bank, the product summing stage and the update stage.
// A finished result waits in the output register while the next request is taken.
// Asynchronous active-low reset loads the default view and limit and empties the engine.
module burning_ship_escape_time (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [bse_pkg::DIM_BITS-1:0]    pixel_col_i,
  input  logic [bse_pkg::DIM_BITS-1:0]    pixel_row_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [bse_pkg::DIM_BITS-1:0]    out_col_o,
  output logic [bse_pkg::DIM_BITS-1:0]    out_row_o,
  output logic [bse_pkg::CNT_W-1:0]       iterations_o,
  output logic                            inside_res_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [bse_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [bse_pkg::VAL_W-1:0]       cfg_data_i
);

  bse_pkg::val_t  real_origin_q, imag_origin_q;
  bse_pkg::step_t real_step_q, imag_step_q;
  bse_pkg::cnt_t  iter_limit_q;
  bse_pkg::cmd_t  cmd;
  bse_pkg::sts_t  sts;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      real_origin_q <= bse_pkg::REAL_ORIGIN_RST;
      imag_origin_q <= bse_pkg::IMAG_ORIGIN_RST;
      real_step_q   <= bse_pkg::REAL_STEP_RST;
      imag_step_q   <= bse_pkg::IMAG_STEP_RST;
      iter_limit_q  <= bse_pkg::ITER_LIMIT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (bse_pkg::cfg_reg_e'(cfg_index_i))
        bse_pkg::REG_REAL_ORIGIN: real_origin_q <= bse_pkg::val_t'(cfg_data_i);
        bse_pkg::REG_IMAG_ORIGIN: imag_origin_q <= bse_pkg::val_t'(cfg_data_i);
        bse_pkg::REG_REAL_STEP:   real_step_q   <= cfg_data_i[bse_pkg::STEP_W-1:0];
        bse_pkg::REG_IMAG_STEP:   imag_step_q   <= cfg_data_i[bse_pkg::STEP_W-1:0];
        bse_pkg::REG_ITER_LIMIT:  iter_limit_q  <= cfg_data_i[bse_pkg::CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  bse_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bse_datapath u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .pixel_col_i       (pixel_col_i),
    .pixel_row_i       (pixel_row_i),
    .real_origin_i     (real_origin_q),
    .imag_origin_i     (imag_origin_q),
    .real_step_i       (real_step_q),
    .imag_step_i       (imag_step_q),
    .iteration_limit_i (iter_limit_q),
    .out_stall_i       (out_stall_i),
    .out_valid_o       (out_valid_o),
    .out_col_o         (out_col_o),
    .out_row_o         (out_row_o),
    .iterations_o      (iterations_o),
    .inside_res_o      (inside_res_o)
  );

endmodule

// ----- sv/bse_checker.sv -----
// Port-level assertion checker for the escape-time engine and its bind statement.
module bse_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [bse_pkg::DIM_BITS-1:0]  out_col_o,
  input logic [bse_pkg::DIM_BITS-1:0]  out_row_o,
  input logic [bse_pkg::CNT_W-1:0]     iterations_o,
  input logic                          inside_res_o,
  input logic                          cfg_valid_i,
  input logic                          cfg_ready_o,
  input logic [bse_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input logic [bse_pkg::VAL_W-1:0]     cfg_data_i
);

  bse_pkg::cnt_t lim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_q <= bse_pkg::ITER_LIMIT_RST;
    end else if (cfg_valid_i && cfg_ready_o && (cfg_index_i == bse_pkg::REG_ITER_LIMIT)) begin
      lim_q <= cfg_data_i[bse_pkg::CNT_W-1:0];
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_col_o) && $stable(out_row_o)
      && $stable(iterations_o) && $stable(inside_res_o))
    else $error("Stalled result changed or dropped.");

  a_inside_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (inside_res_o == (iterations_o == lim_q)))
    else $error("Inside flag disagrees with the iteration count.");

  a_iter_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (iterations_o <= lim_q))
    else $error("Iteration count exceeds the limit.");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("Engine took a second request while working.");

  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("Result appeared while the engine was idle.");

endmodule

bind burning_ship_escape_time bse_checker u_bse_checker (.*);

// ----- dv/burning_ship_escape_time_tb.sv -----
// Self-checking testbench for the burning ship escape-time engine with directed and random views.
module burning_ship_escape_time_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     FRAC_BITS   = bse_pkg::FRAC_BITS;
  localparam int     VAL_W       = bse_pkg::VAL_W;
  localparam int     STEP_W      = bse_pkg::STEP_W;
  localparam int     DIM_BITS    = bse_pkg::DIM_BITS;
  localparam int     CNT_W       = bse_pkg::CNT_W;
  localparam int     CFG_IDX_W   = bse_pkg::CFG_IDX_W;
  localparam int     CYCLE_LIMIT = 5_000_000;
  localparam int     MAX_LATENCY = 4 + 3 * 4095;
  localparam int     PHASE_ITEMS = 210;
  localparam longint UNIT        = longint'(1) << FRAC_BITS;
  localparam logic [VAL_W-1:0] GRID_STEP = VAL_W'(UNIT >> 10);

  typedef struct packed {
    bse_pkg::dim_t col;
    bse_pkg::dim_t row;
    bse_pkg::cnt_t iters;
    logic          in_set;
  } ship_result_t;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_stall_o;
  logic [DIM_BITS-1:0]  pixel_col_i = '0;
  logic [DIM_BITS-1:0]  pixel_row_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [DIM_BITS-1:0]  out_col_o;
  logic [DIM_BITS-1:0]  out_row_o;
  logic [CNT_W-1:0]     iterations_o;
  logic                 inside_res_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [VAL_W-1:0]     cfg_data_i  = '0;

  bse_pkg::val_t  view_re0     = bse_pkg::REAL_ORIGIN_RST;
  bse_pkg::val_t  view_im0     = bse_pkg::IMAG_ORIGIN_RST;
  bse_pkg::step_t view_re_step = bse_pkg::REAL_STEP_RST;
  bse_pkg::step_t view_im_step = bse_pkg::IMAG_STEP_RST;
  bse_pkg::cnt_t  view_limit   = bse_pkg::ITER_LIMIT_RST;

  ship_result_t pending_results[$];
  int unsigned  fail_count    = 0;
  int unsigned  cycle_count   = 0;
  int unsigned  send_idle_pct = 0;
  int unsigned  stall_pct     = 0;

  burning_ship_escape_time uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .pixel_col_i  (pixel_col_i),
    .pixel_row_i  (pixel_row_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_col_o    (out_col_o),
    .out_row_o    (out_row_o),
    .iterations_o (iterations_o),
    .inside_res_o (inside_res_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < stall_pct);
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("burning_ship_escape_time regression: fail");
      $finish;
    end
  end

  function automatic bse_pkg::val_t saturate(input longint v);
    if (v > longint'(bse_pkg::VAL_MAX)) begin
      return bse_pkg::VAL_MAX;
    end else if (v < longint'(bse_pkg::VAL_MIN)) begin
      return bse_pkg::VAL_MIN;
    end
    return bse_pkg::val_t'(v);
  endfunction

  function automatic bse_pkg::mag_t magnitude(input bse_pkg::val_t v);
    return v[VAL_W-1] ? bse_pkg::mag_t'(-v) : bse_pkg::mag_t'(v);
  endfunction

  function automatic longint scaled_product(input bse_pkg::mag_t x, input bse_pkg::mag_t y,
                                            input int unsigned sh);
    bse_pkg::prod_t p;
    p = {{VAL_W{1'b0}}, x} * {{VAL_W{1'b0}}, y};
    p = p >> sh;
    if (p > bse_pkg::prod_t'(bse_pkg::VAL_MAX)) begin
      return longint'(bse_pkg::VAL_MAX);
    end
    return longint'(p[63:0]);
  endfunction

  function automatic bse_pkg::val_t pixel_coord(input bse_pkg::val_t origin,
                                                input bse_pkg::step_t step,
                                                input bse_pkg::dim_t idx);
    longint span;
    span = longint'({{(64-STEP_W){1'b0}}, step}) * longint'({{(64-DIM_BITS){1'b0}}, idx});
    return saturate(longint'(origin) + span);
  endfunction

  function automatic ship_result_t escape_time(input bse_pkg::dim_t col,
                                               input bse_pkg::dim_t row);
    ship_result_t  res;
    bse_pkg::val_t cr, ci, zr, zi;
    bse_pkg::mag_t a, b;
    longint        aa, bb, ab2;
    int            n;
    logic          escaped;
    cr      = pixel_coord(view_re0, view_re_step, col);
    ci      = pixel_coord(view_im0, view_im_step, row);
    zr      = cr;
    zi      = ci;
    n       = 0;
    escaped = 1'b0;
    while (!escaped && n < int'(view_limit)) begin
      a  = magnitude(zr);
      b  = magnitude(zi);
      aa = scaled_product(a, a, FRAC_BITS);
      bb = scaled_product(b, b, FRAC_BITS);
      if (aa + bb >= longint'(bse_pkg::FOUR)) begin
        escaped = 1'b1;
      end else begin
        ab2 = scaled_product(a, b, FRAC_BITS - 1);
        zr  = saturate(aa - bb + longint'(cr));
        zi  = saturate(ab2 + longint'(ci));
        n++;
      end
    end
    res.col    = col;
    res.row    = row;
    res.iters  = bse_pkg::cnt_t'(n);
    res.in_set = (n == int'(view_limit));
    return res;
  endfunction

  function automatic logic [VAL_W-1:0] rand_word();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[VAL_W-1:0];
  endfunction

  function automatic longint unsigned rand_below(input longint unsigned span);
    return {$urandom, $urandom} % span;
  endfunction

  task automatic send_pixel(input bse_pkg::dim_t col, input bse_pkg::dim_t row);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    pixel_col_i <= col;
    pixel_row_i <= row;
    do @(posedge clk_i); while (in_stall_o);
    pending_results.push_back(escape_time(col, row));
  endtask

  task automatic await_idle();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input bse_pkg::cfg_reg_e idx, input logic [VAL_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      bse_pkg::REG_REAL_ORIGIN: view_re0     = bse_pkg::val_t'(data);
      bse_pkg::REG_IMAG_ORIGIN: view_im0     = bse_pkg::val_t'(data);
      bse_pkg::REG_REAL_STEP:   view_re_step = data[STEP_W-1:0];
      bse_pkg::REG_IMAG_STEP:   view_im_step = data[STEP_W-1:0];
      bse_pkg::REG_ITER_LIMIT:  view_limit   = data[CNT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic program_view(input logic [VAL_W-1:0] re0, input logic [VAL_W-1:0] im0,
                              input logic [VAL_W-1:0] re_step,
                              input logic [VAL_W-1:0] im_step,
                              input logic [VAL_W-1:0] lim_word);
    await_idle();
    write_reg(bse_pkg::REG_REAL_ORIGIN, re0);
    write_reg(bse_pkg::REG_IMAG_ORIGIN, im0);
    write_reg(bse_pkg::REG_REAL_STEP, re_step);
    write_reg(bse_pkg::REG_IMAG_STEP, im_step);
    write_reg(bse_pkg::REG_ITER_LIMIT, lim_word);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic program_random_view(input bse_pkg::cnt_t lim);
    logic [VAL_W-1:0] re0, im0, re_step, im_step, lim_word, noise;
    noise    = rand_word();
    lim_word = {{(VAL_W-CNT_W){1'b0}}, lim};
    if ($urandom_range(0, 3) == 0) begin
      re0     = rand_word();
      im0     = rand_word();
      re_step = rand_word();
      im_step = rand_word();
      lim_word[VAL_W-1:CNT_W] = noise[VAL_W-1:CNT_W];
    end else begin
      re0     = bse_pkg::val_t'(-(5 * UNIT / 2) + longint'(rand_below(3 * UNIT)));
      im0     = bse_pkg::val_t'(-2 * UNIT + longint'(rand_below(3 * UNIT)));
      re_step = VAL_W'(rand_below(longint'(1) << $urandom_range(1, 34)));
      im_step = VAL_W'(rand_below(longint'(1) << $urandom_range(1, 34)));
    end
    program_view(re0, im0, re_step, im_step, lim_word);
  endtask

  task automatic test_reset_view();
    send_pixel(0, 0);
    send_pixel(4095, 4095);
    send_pixel(1023, 1023);
    send_pixel(511, 0);
    send_pixel(0, 511);
  endtask

  task automatic test_iteration_limits();
    program_view('0, '0, '0, '0, 0);
    send_pixel(4095, 0);
    program_view(bse_pkg::val_t'(-2 * UNIT), bse_pkg::val_t'(-2 * UNIT), GRID_STEP, GRID_STEP,
                 1);
    send_pixel(0, 0);
    send_pixel(2048, 2048);
    send_pixel(4095, 4095);
    send_pixel(1536, 2048);
    program_view(bse_pkg::val_t'(-2 * UNIT), bse_pkg::val_t'(-2 * UNIT), GRID_STEP, GRID_STEP,
                 4095);
    send_pixel(2048, 2048);
    send_pixel(1536, 2200);
    send_pixel(3000, 1000);
  endtask

  task automatic test_coordinate_saturation();
    program_view(bse_pkg::VAL_MAX, bse_pkg::VAL_MIN, '1, '1,
                 {{(VAL_W-CNT_W){1'b1}}, bse_pkg::cnt_t'(5)});
    send_pixel(0, 0);
    send_pixel(4095, 4095);
    send_pixel(4095, 0);
    program_view(bse_pkg::VAL_MIN, bse_pkg::VAL_MAX, '0, '0, 3);
    send_pixel(0, 4095);
  endtask

  task automatic test_unused_registers();
    program_view(bse_pkg::val_t'(-UNIT), bse_pkg::val_t'(-UNIT / 2), VAL_W'(UNIT >> 14),
                 VAL_W'(UNIT >> 14), 20);
    send_pixel(bse_pkg::dim_t'($urandom), bse_pkg::dim_t'($urandom));
    await_idle();
    for (int k = 1; k <= 3; k++) begin
      write_reg(bse_pkg::cfg_reg_e'(int'(bse_pkg::REG_ITER_LIMIT) + k), rand_word());
    end
    cfg_valid_i <= 1'b0;
    send_pixel(bse_pkg::dim_t'($urandom), bse_pkg::dim_t'($urandom));
    send_pixel(bse_pkg::dim_t'($urandom), bse_pkg::dim_t'($urandom));
  endtask

  task automatic test_random_views();
    int            sent;
    int            block;
    int            r;
    bse_pkg::cnt_t lim;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 0;
          stall_pct     = 0;
        end
        1: begin
          send_idle_pct = 75;
          stall_pct     = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct     = 75;
        end
        default: begin
          send_idle_pct = 21;
          stall_pct     = 21;
        end
      endcase
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        r = $urandom_range(0, 99);
        if (r < 60) begin
          lim = bse_pkg::cnt_t'($urandom_range(1, 16));
        end else if (r < 90) begin
          lim = bse_pkg::cnt_t'($urandom_range(17, 128));
        end else begin
          lim = bse_pkg::cnt_t'($urandom_range(129, 400));
        end
        program_random_view(lim);
        block = (PHASE_ITEMS - sent < 30) ? PHASE_ITEMS - sent : 30;
        repeat (block) send_pixel(bse_pkg::dim_t'($urandom), bse_pkg::dim_t'($urandom));
        sent += block;
      end
      program_random_view('1);
      repeat (4) send_pixel(bse_pkg::dim_t'($urandom), bse_pkg::dim_t'($urandom));
    end
  endtask

  always @(posedge clk_i) begin : check_results
    ship_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        fail_count++;
        $display("%0t: result col %0d row %0d arrived with no request waiting",
                 $time, out_col_o, out_row_o);
      end else begin
        want = pending_results.pop_front();
        if (out_col_o !== want.col) begin
          fail_count++;
          $display("%0t: out_col expected %0d got %0d", $time, want.col, out_col_o);
        end
        if (out_row_o !== want.row) begin
          fail_count++;
          $display("%0t: out_row expected %0d got %0d", $time, want.row, out_row_o);
        end
        if (iterations_o !== want.iters) begin
          fail_count++;
          $display("%0t: iterations expected %0d got %0d (col %0d row %0d)",
                   $time, want.iters, iterations_o, want.col, want.row);
        end
        if (inside_res_o !== want.in_set) begin
          fail_count++;
          $display("%0t: inside_res expected %0b got %0b (col %0d row %0d)",
                   $time, want.in_set, inside_res_o, want.col, want.row);
        end
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_reset_view();
    test_iteration_limits();
    test_coordinate_saturation();
    test_unused_registers();
    test_random_views();
    await_idle();
    repeat (MAX_LATENCY) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("burning_ship_escape_time regression: pass");
    end else begin
      $display("burning_ship_escape_time regression: fail");
    end
    $finish;
  end

endmodule
